>>> rtl/tsmu_pkg.sv
// shared types and constants for the typed stack with mark unwind
package tsmu_pkg;

    localparam int DEPTH        = 32;
    localparam int PAYLOAD_BITS = 64;
    localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W        = 6;
    localparam int PORT_PAY_W   = 64;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_READ   = 2'd2,
        ACT_UNWIND = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_ANY    = 3'd0,
        KIND_MARK   = 3'd1,
        KIND_DEST   = 3'd2,
        KIND_ACTION = 3'd3,
        KIND_OBJECT = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_WRONG_TYPE = 3'd2,
        ST_FULL       = 3'd3,
        ST_NO_MARK    = 3'd4,
        ST_NO_ENTRY   = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]              kind;
        logic                    cleanup;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

endpackage

>>> rtl/typed_stack_with_mark_unwind_unit.sv
// typed lifo stack with pop, read at depth and unwind to mark
// timing: push and failed requests give their word in the cycle after start; pop and read
//   give it through the memory read register r_rd and then the result registers
// flow: pop, read and unwind hold o_busy until done; unwind removes one entry per
//   cycle, set by the single read port, then gives a no-mark word when no mark is found
// reset: synchronous, clears the stack level and control; entry memory is not cleared
// results are strobed by o_valid for one cycle; the receiver cannot stall
module typed_stack_with_mark_unwind_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_entry_kind,
    input  logic        i_with_cleanup,
    input  logic [63:0] i_payload,
    input  logic [5:0]  i_depth,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [2:0]  o_out_kind,
    output logic [63:0] o_out_payload,
    output logic        o_cleanup_request,
    output logic [5:0]  o_level,
    output logic        o_last
);

    // one-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,  // waiting for a request
        S_POP  = 5'b00010,  // popped entry arriving from memory
        S_READ = 5'b00100,  // entry at depth arriving from memory
        S_UNW  = 5'b01000,  // unwind: one removed entry per cycle
        S_MISS = 5'b10000   // unwind ran dry, report mark not found
    } t_state;

    t_state r_state, n_state;
    logic [tsmu_pkg::LVL_W-1:0] r_top, n_top;

    // request fields held while the request is in flight
    logic [2:0]                        r_want, n_want;
    logic [tsmu_pkg::PAYLOAD_BITS-1:0] r_seek, n_seek;

    // result word registers
    logic                              r_valid, n_valid;
    logic [2:0]                        r_status, n_status;
    logic [2:0]                        r_kind, n_kind;
    logic [tsmu_pkg::PORT_PAY_W-1:0]   r_payload, n_payload;
    logic                              r_cleanup, n_cleanup;
    logic [tsmu_pkg::LVL_W-1:0]        r_level, n_level;
    logic                              r_last, n_last;

    // entry memory, one write and one registered read per cycle
    tsmu_pkg::t_entry                  mem [tsmu_pkg::DEPTH];
    tsmu_pkg::t_entry                  r_rd;
    logic                              mem_we, mem_re;
    logic [tsmu_pkg::ADDR_W-1:0]       mem_wa, mem_ra;
    tsmu_pkg::t_entry                  mem_wd;

    logic [tsmu_pkg::LVL_W-1:0]        top_m1, rd_idx;
    logic                              accept, kind_ok, full, hit;
    logic [tsmu_pkg::PAYLOAD_BITS-1:0] in_pay;

    assign accept  = i_start && (r_state == S_IDLE);
    assign o_busy  = (r_state != S_IDLE);
    assign top_m1  = r_top - tsmu_pkg::LVL_W'(1);
    assign rd_idx  = top_m1 - i_depth;
    assign in_pay  = i_payload[tsmu_pkg::PAYLOAD_BITS-1:0];
    assign full    = (r_top >= tsmu_pkg::LVL_W'(tsmu_pkg::DEPTH));
    assign kind_ok = (i_entry_kind >= tsmu_pkg::KIND_MARK)
                  && (i_entry_kind <= tsmu_pkg::KIND_OBJECT);
    // unwind stops at a mark carrying the sought value
    assign hit     = (r_rd.kind == tsmu_pkg::KIND_MARK) && (r_rd.payload == r_seek);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_top     = r_top;
        n_want    = r_want;
        n_seek    = r_seek;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_kind    = r_kind;
        n_payload = r_payload;
        n_cleanup = r_cleanup;
        n_level   = r_level;
        n_last    = r_last;
        mem_we    = 1'b0;
        mem_wa    = r_top[tsmu_pkg::ADDR_W-1:0];
        mem_wd    = '{kind: i_entry_kind, cleanup: i_with_cleanup, payload: in_pay};
        mem_re    = 1'b0;
        mem_ra    = top_m1[tsmu_pkg::ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_want    = i_entry_kind;
                    n_seek    = in_pay;
                    n_kind    = tsmu_pkg::KIND_ANY;
                    n_payload = '0;
                    n_cleanup = 1'b0;
                    n_last    = 1'b1;
                    n_level   = r_top;
                    unique case (tsmu_pkg::t_action'(i_action))
                        tsmu_pkg::ACT_PUSH: begin
                            n_valid = 1'b1;
                            priority if (!kind_ok) begin
                                n_status = tsmu_pkg::ST_WRONG_TYPE;
                            end else if (full) begin
                                n_status = tsmu_pkg::ST_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                n_top    = r_top + tsmu_pkg::LVL_W'(1);
                                n_level  = n_top;
                                n_status = tsmu_pkg::ST_OK;
                            end
                        end
                        tsmu_pkg::ACT_POP: begin
                            if (r_top == '0) begin
                                n_valid  = 1'b1;
                                n_status = tsmu_pkg::ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_top   = top_m1;
                                n_state = S_POP;
                            end
                        end
                        tsmu_pkg::ACT_READ: begin
                            if (i_depth >= r_top) begin
                                n_valid  = 1'b1;
                                n_status = tsmu_pkg::ST_NO_ENTRY;
                            end else begin
                                mem_re  = 1'b1;
                                mem_ra  = rd_idx[tsmu_pkg::ADDR_W-1:0];
                                n_state = S_READ;
                            end
                        end
                        tsmu_pkg::ACT_UNWIND: begin
                            if (r_top == '0) begin
                                n_valid  = 1'b1;
                                n_status = tsmu_pkg::ST_NO_MARK;
                            end else begin
                                mem_re  = 1'b1;
                                n_top   = top_m1;
                                n_state = S_UNW;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP: begin
                // wrong type still removes the entry but suppresses its cleanup
                n_valid   = 1'b1;
                n_kind    = r_rd.kind;
                n_payload = tsmu_pkg::PORT_PAY_W'(r_rd.payload);
                n_level   = r_top;
                n_last    = 1'b1;
                if ((r_want != tsmu_pkg::KIND_ANY) && (r_rd.kind != r_want)) begin
                    n_status  = tsmu_pkg::ST_WRONG_TYPE;
                    n_cleanup = 1'b0;
                end else begin
                    n_status  = tsmu_pkg::ST_OK;
                    n_cleanup = r_rd.cleanup;
                end
                n_state = S_IDLE;
            end
            S_READ: begin
                n_valid   = 1'b1;
                n_status  = tsmu_pkg::ST_OK;
                n_kind    = r_rd.kind;
                n_payload = tsmu_pkg::PORT_PAY_W'(r_rd.payload);
                n_cleanup = 1'b0;
                n_level   = r_top;
                n_last    = 1'b1;
                n_state   = S_IDLE;
            end
            S_UNW: begin
                // report the entry just removed, fetch the next one in parallel
                n_valid   = 1'b1;
                n_status  = tsmu_pkg::ST_OK;
                n_kind    = r_rd.kind;
                n_payload = tsmu_pkg::PORT_PAY_W'(r_rd.payload);
                n_cleanup = r_rd.cleanup;
                n_level   = r_top;
                n_last    = hit;
                priority if (hit) begin
                    n_state = S_IDLE;
                end else if (r_top == '0) begin
                    n_state = S_MISS;
                end else begin
                    mem_re = 1'b1;
                    n_top  = top_m1;
                end
            end
            S_MISS: begin
                n_valid   = 1'b1;
                n_status  = tsmu_pkg::ST_NO_MARK;
                n_kind    = tsmu_pkg::KIND_ANY;
                n_payload = '0;
                n_cleanup = 1'b0;
                n_level   = '0;
                n_last    = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_valid <= n_valid;
        end
        r_want    <= n_want;
        r_seek    <= n_seek;
        r_status  <= n_status;
        r_kind    <= n_kind;
        r_payload <= n_payload;
        r_cleanup <= n_cleanup;
        r_level   <= n_level;
        r_last    <= n_last;
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_out_kind        = r_kind;
    assign o_out_payload     = r_payload;
    assign o_cleanup_request = r_cleanup;
    assign o_level           = r_level;
    assign o_last            = r_last;

endmodule
